[rtl/core/rhs_pkg.sv]
// package for the resource hazard scoreboard: sizes, codes, item types
// and controller/datapath interface structs; no dependencies
package rhs_pkg;

  localparam int unsigned KIND_MAX     = 7;
  localparam int unsigned ACTIVE_DEPTH = 32;
  localparam int unsigned RECORD_DEPTH = 16;

  localparam int unsigned ACW = $clog2(ACTIVE_DEPTH + 1);
  localparam int unsigned AIW = $clog2(ACTIVE_DEPTH);
  localparam int unsigned RCW = $clog2(RECORD_DEPTH + 1);
  localparam int unsigned RIW = $clog2(RECORD_DEPTH);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CHECK  = 2'd1;
  localparam logic [1:0] OP_COMMIT = 2'd2;

  localparam logic [1:0] ACT_INVALID  = 2'd0;
  localparam logic [1:0] ACT_CONTINUE = 2'd1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  kind;
    logic [63:0] handle;
    logic        is_write;
    logic [1:0]  commit_action;
    logic        reset_hazards;
  } in_item_t;

  typedef struct packed {
    logic accepted;
    logic read_after_write;
    logic write_after_read;
    logic write_after_write;
    logic hazard;
    logic active_now;
    logic overflow;
  } out_item_t;

  // tag: write bit on top, kind below
  typedef logic [3:0] tag_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_WALK,
    ST_FIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic start;
    logic add;
    logic step;
    logic fin;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_add;
    logic need_walk;
    logic walk_last;
  } dp_sts_t;

endpackage

[rtl/core/rhs_datapath.sv]
// scoreboard datapath: record and active stores, parallel active match,
// record walk index, hazard accumulators and result register; uses rhs_pkg
module rhs_datapath import rhs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output out_item_t out_item_o
);

  logic [63:0]    act_h_q [ACTIVE_DEPTH];
  tag_t           act_t_q [ACTIVE_DEPTH];
  logic [ACW-1:0] act_cnt_q;
  logic           act_flag_q, act_ovf_q;
  logic [63:0]    rec_h_q [RECORD_DEPTH];
  tag_t           rec_t_q [RECORD_DEPTH];
  logic [RCW-1:0] rec_cnt_q;
  logic           rec_ovf_q;

  in_item_t       op_q;
  logic           clr_q;
  logic [RIW-1:0] idx_q;
  logic           acc_q, raw_q, war_q, waw_q;
  out_item_t      res_q;

  logic [63:0] cur_h;
  tag_t        cur_t, add_t;
  logic        hit_rd, hit_wr, present, rec_dup, add_ok, clear_cmd;
  logic        in_clear, in_keep;

  assign cur_h = rec_h_q[idx_q];
  assign cur_t = rec_t_q[idx_q];

  // parallel match of the current record entry against the active set
  always_comb begin
    hit_rd = 1'b0;
    hit_wr = 1'b0;
    for (int i = 0; i < ACTIVE_DEPTH; i++) begin
      if ((ACW'(i) < act_cnt_q) && (act_h_q[i] == cur_h) &&
          (act_t_q[i][2:0] == cur_t[2:0])) begin
        if (act_t_q[i][3]) hit_wr = 1'b1;
        else               hit_rd = 1'b1;
      end
    end
  end

  assign present = cur_t[3] ? hit_wr : hit_rd;

  // duplicate search over the record for an add
  assign add_t = {op_q.is_write, op_q.kind};
  always_comb begin
    rec_dup = 1'b0;
    for (int j = 0; j < RECORD_DEPTH; j++) begin
      if ((RCW'(j) < rec_cnt_q) && (rec_t_q[j] == add_t) &&
          (rec_h_q[j] == op_q.handle)) rec_dup = 1'b1;
    end
  end

  assign add_ok = (op_q.handle != 64'd0) && (32'(op_q.kind) <= KIND_MAX) && !rec_dup;

  assign in_clear  = (in_item_i.commit_action == ACT_INVALID) || in_item_i.reset_hazards;
  assign in_keep   = (in_item_i.commit_action == ACT_CONTINUE) && act_flag_q;
  assign clear_cmd = cmd_i.start && (in_item_i.opcode == OP_COMMIT) && (in_clear || !in_keep);

  always_comb begin
    sts_o.is_add    = (in_item_i.opcode == OP_ADD);
    sts_o.need_walk = (rec_cnt_q != '0) &&
                      (((in_item_i.opcode == OP_CHECK) && act_flag_q &&
                        !(act_ovf_q || rec_ovf_q)) ||
                       ((in_item_i.opcode == OP_COMMIT) && !in_clear));
    sts_o.walk_last = (RCW'(idx_q) == rec_cnt_q - RCW'(1));
  end

  // control state of the stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_cnt_q  <= '0;
      act_flag_q <= 1'b0;
      act_ovf_q  <= 1'b0;
      rec_cnt_q  <= '0;
      rec_ovf_q  <= 1'b0;
    end else begin
      if (clear_cmd) begin
        act_cnt_q <= '0;
        act_ovf_q <= 1'b0;
      end
      if (cmd_i.add && add_ok) begin
        if (rec_cnt_q == RCW'(RECORD_DEPTH)) rec_ovf_q <= 1'b1;
        else                                 rec_cnt_q <= rec_cnt_q + RCW'(1);
      end
      if (cmd_i.step && (op_q.opcode == OP_COMMIT) && !present) begin
        if (act_cnt_q == ACW'(ACTIVE_DEPTH)) act_ovf_q <= 1'b1;
        else                                 act_cnt_q <= act_cnt_q + ACW'(1);
      end
      if (cmd_i.fin && (op_q.opcode == OP_COMMIT)) begin
        if (!clr_q && rec_ovf_q) act_ovf_q <= 1'b1;
        act_flag_q <= (act_cnt_q != '0);
        rec_cnt_q  <= '0;
        rec_ovf_q  <= 1'b0;
      end
    end
  end

  // store contents and per-item working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= in_item_i;
      clr_q <= in_clear;
      idx_q <= '0;
      acc_q <= 1'b0;
      if ((in_item_i.opcode == OP_CHECK) && act_flag_q && (act_ovf_q || rec_ovf_q)) begin
        raw_q <= 1'b1;
        war_q <= 1'b1;
        waw_q <= 1'b1;
      end else begin
        raw_q <= 1'b0;
        war_q <= 1'b0;
        waw_q <= 1'b0;
      end
    end
    if (cmd_i.add && add_ok && (rec_cnt_q != RCW'(RECORD_DEPTH))) begin
      rec_t_q[rec_cnt_q[RIW-1:0]] <= add_t;
      rec_h_q[rec_cnt_q[RIW-1:0]] <= op_q.handle;
      acc_q <= 1'b1;
    end
    if (cmd_i.step) begin
      idx_q <= idx_q + RIW'(1);
      if (op_q.opcode == OP_CHECK) begin
        if (cur_t[3]) begin
          if (hit_rd) war_q <= 1'b1;
          if (hit_wr) waw_q <= 1'b1;
        end else if (hit_wr) begin
          raw_q <= 1'b1;
        end
      end else if (!present && (act_cnt_q != ACW'(ACTIVE_DEPTH))) begin
        act_t_q[act_cnt_q[AIW-1:0]] <= cur_t;
        act_h_q[act_cnt_q[AIW-1:0]] <= cur_h;
      end
    end
    if (cmd_i.emit) begin
      res_q.accepted          <= acc_q;
      res_q.read_after_write  <= raw_q;
      res_q.write_after_read  <= war_q;
      res_q.write_after_write <= waw_q;
      res_q.hazard            <= raw_q | war_q | waw_q;
      res_q.active_now        <= act_flag_q;
      res_q.overflow          <= act_ovf_q | rec_ovf_q;
    end
  end

  assign out_item_o = res_q;

endmodule

[rtl/core/rhs_ctrl.sv]
// scoreboard controller: sequences add, record walk, commit finish and
// result hand-off; owns the channel handshakes; uses rhs_pkg
module rhs_ctrl import rhs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.is_add)         state_d = ST_ADD;
          else if (sts_i.need_walk) state_d = ST_WALK;
          else                      state_d = ST_FIN;
        end
      end
      ST_ADD:  state_d = ST_DONE;
      ST_WALK: if (sts_i.walk_last) state_d = ST_FIN;
      ST_FIN:  state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      ST_ADD:  cmd_o.add  = 1'b1;
      ST_WALK: cmd_o.step = 1'b1;
      ST_FIN:  cmd_o.fin  = 1'b1;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/resource_hazard_scoreboard.sv]
// channel    | signals                          | direction
// input item | in_valid_i, in_ready_o, in_item_i | in
// result     | out_valid_o, out_ready_i, out_item_o | out
//
// an add, an opcode three and a check or commit with no record walk pass
// through ST_ADD or ST_FIN to ST_DONE, which loads the result register; a
// walked check or commit steps ST_WALK one record entry at a time, up to 16,
// each against a parallel match over the active set. a result waits in the
// output register while the next item is accepted and worked; that item holds
// in ST_DONE until the register is free. reset clears counts and flags at once.
// top level of the resource hazard scoreboard; uses rhs_pkg, rhs_ctrl,
// rhs_datapath
module resource_hazard_scoreboard import rhs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  rhs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rhs_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("accepted twice");
  a_hazard_or: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.hazard == (out_item_o.read_after_write |
      out_item_o.write_after_read | out_item_o.write_after_write)))
    else $error("hazard summary mismatch");
  a_idle_no_hazard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.active_now) |-> !out_item_o.hazard)
    else $error("hazard with empty active set");
`endif

endmodule

[sim/resource_hazard_scoreboard_tb.sv]
// self-checking testbench for resource_hazard_scoreboard: directed table then random items,
// each result checked against an in-bench hazard predictor; depends on rhs_pkg and the rtl
`timescale 1ns / 1ps

module resource_hazard_scoreboard_tb;
  import rhs_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  resource_hazard_scoreboard u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [63:0] act_h [ACTIVE_DEPTH];
  tag_t        act_t [ACTIVE_DEPTH];
  int          act_n;
  bit          act_on, act_ovf;
  logic [63:0] rec_h [RECORD_DEPTH];
  tag_t        rec_t [RECORD_DEPTH];
  int          rec_n;
  bit          rec_ovf;

  out_item_t expected_q[$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        stim_done = 1'b0;
  bit        hold_off = 1'b0;
  logic [63:0] handle_pool [8];

  function automatic bit active_holds(tag_t t, logic [63:0] h);
    for (int i = 0; i < act_n; i++)
      if (act_t[i] == t && act_h[i] == h) return 1'b1;
    return 1'b0;
  endfunction

  function automatic out_item_t predict_hazards(in_item_t it);
    out_item_t r;
    tag_t t;
    bit dup;
    r = '0;
    t = {it.is_write, it.kind};
    if (it.opcode == OP_ADD) begin
      dup = 1'b0;
      for (int i = 0; i < rec_n; i++)
        if (rec_t[i] == t && rec_h[i] == it.handle) dup = 1'b1;
      if (it.handle != 0 && it.kind <= KIND_MAX && !dup) begin
        if (rec_n >= RECORD_DEPTH) rec_ovf = 1'b1;
        else begin
          rec_t[rec_n] = t;
          rec_h[rec_n] = it.handle;
          rec_n++;
          r.accepted = 1'b1;
        end
      end
    end else if (it.opcode == OP_CHECK) begin
      if (act_on) begin
        if (act_ovf || rec_ovf) begin
          r.read_after_write = 1'b1;
          r.write_after_read = 1'b1;
          r.write_after_write = 1'b1;
        end else begin
          for (int i = 0; i < rec_n; i++) begin
            if (rec_t[i][3]) begin
              if (active_holds({1'b0, rec_t[i][2:0]}, rec_h[i])) r.write_after_read = 1'b1;
              if (active_holds(rec_t[i], rec_h[i])) r.write_after_write = 1'b1;
            end else if (active_holds({1'b1, rec_t[i][2:0]}, rec_h[i])) begin
              r.read_after_write = 1'b1;
            end
          end
        end
      end
    end else if (it.opcode == OP_COMMIT) begin
      if (it.commit_action == ACT_INVALID || it.reset_hazards) begin
        act_n = 0;
        act_ovf = 1'b0;
      end else begin
        if (!(it.commit_action == ACT_CONTINUE && act_on)) begin
          act_n = 0;
          act_ovf = 1'b0;
        end
        for (int i = 0; i < rec_n; i++) begin
          if (!active_holds(rec_t[i], rec_h[i])) begin
            if (act_n >= ACTIVE_DEPTH) act_ovf = 1'b1;
            else begin
              act_t[act_n] = rec_t[i];
              act_h[act_n] = rec_h[i];
              act_n++;
            end
          end
        end
        if (rec_ovf) act_ovf = 1'b1;
      end
      act_on = act_n != 0;
      rec_n = 0;
      rec_ovf = 1'b0;
    end
    r.hazard = r.read_after_write | r.write_after_read | r.write_after_write;
    r.active_now = act_on;
    r.overflow = act_ovf | rec_ovf;
    return r;
  endfunction

  // valid stays up after an accept until the next call or the caller drops it
  task automatic send_item(in_item_t it, bit pause_first);
    int gap;
    gap = pause_first ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.insert(expected_q.size(), predict_hazards(it));
  endtask

  function automatic in_item_t make_item(logic [1:0] op, logic [2:0] k, logic [63:0] h,
                                         bit w, logic [1:0] act, bit rz);
    in_item_t it;
    it.opcode = op;
    it.kind = k;
    it.handle = h;
    it.is_write = w;
    it.commit_action = act;
    it.reset_hazards = rz;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int sel;
    it = '0;
    sel = $urandom_range(0, 99);
    it.opcode = (sel < 60) ? OP_ADD : (sel < 82) ? OP_CHECK : (sel < 97) ? OP_COMMIT : 2'd3;
    it.kind = $urandom_range(0, 1) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
    it.is_write = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: it.handle = 64'd0;
      1: it.handle = {$urandom, $urandom};
      default: it.handle = handle_pool[$urandom_range(0, 7)];
    endcase
    sel = $urandom_range(0, 9);
    it.commit_action = (sel < 2) ? ACT_INVALID : (sel < 7) ? ACT_CONTINUE : 2'($urandom_range(2, 3));
    it.reset_hazards = ($urandom_range(0, 9) == 0);
    return it;
  endfunction

  // directed table; expected typed only where it is obvious, else 'x'-row uses predictor
  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(in_item_t it, bit typed, out_item_t want);
    dir_row_t r;
    r.it = it;
    r.typed = typed;
    r.want = want;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // receiver
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        do @(posedge clk_i); while (!(out_valid_o && out_ready_i) && !hold_off);
        if (out_valid_o && out_ready_i) begin
          out_item_t want;
          if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", out_item_o);
          end else begin
            want = expected_q.pop_front();
            if (out_item_o !== want) begin
              mismatches++;
              if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, out_item_o);
            end
          end
        end
      end
    end
  end

  // long receiver hold-off, counted here
  initial begin
    @(posedge rst_ni);
    repeat (600) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("resource_hazard_scoreboard_tb failed");
      $finish;
    end
  end

  initial begin
    out_item_t z, w;
    int sent;
    for (int i = 0; i < 8; i++)
      handle_pool[i] = (i == 7) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(i + 1);
    act_n = 0; act_on = 0; act_ovf = 0; rec_n = 0; rec_ovf = 0;
    z = '0;
    // after reset: empty-set check, null and duplicate adds, commits, a hazard check and an opcode three
    add_row(make_item(OP_CHECK, 3'd0, 64'd0, 1'b0, ACT_INVALID, 1'b0), 1'b1, z);
    add_row(make_item(OP_ADD, 3'd0, 64'd0, 1'b1, ACT_INVALID, 1'b0), 1'b1, z);
    w = z; w.accepted = 1'b1;
    add_row(make_item(OP_ADD, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 2'd0, 1'b0), 1'b1, w);
    add_row(make_item(OP_ADD, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 2'd0, 1'b0), 1'b1, z);
    add_row(make_item(OP_ADD, 3'd0, 64'd1, 1'b0, 2'd0, 1'b0), 1'b1, w);
    add_row(make_item(OP_CHECK, 3'd0, 64'd0, 1'b0, 2'd0, 1'b0), 1'b1, z);
    add_row(make_item(OP_COMMIT, 3'd0, 64'd0, 1'b0, ACT_CONTINUE, 1'b0), 1'b0, z);
    add_row(make_item(OP_ADD, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 2'd0, 1'b0), 1'b0, z);
    add_row(make_item(OP_ADD, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 2'd0, 1'b0), 1'b0, z);
    add_row(make_item(OP_ADD, 3'd0, 64'd1, 1'b1, 2'd0, 1'b0), 1'b0, z);
    add_row(make_item(OP_CHECK, 3'd0, 64'd0, 1'b0, 2'd0, 1'b0), 1'b0, z);
    add_row(make_item(2'd3, 3'd5, 64'd9, 1'b1, 2'd3, 1'b1), 1'b0, z);
    add_row(make_item(OP_COMMIT, 3'd0, 64'd0, 1'b0, 2'd3, 1'b0), 1'b0, z);
    add_row(make_item(OP_COMMIT, 3'd0, 64'd0, 1'b0, ACT_CONTINUE, 1'b1), 1'b1, z);
    // record overflow: 17 distinct adds, a commit, an add, then check with an active set
    for (int i = 0; i < 17; i++)
      add_row(make_item(OP_ADD, 3'(i), 64'(i + 100), i[0], 2'd0, 1'b0), 1'b0, z);
    add_row(make_item(OP_COMMIT, 3'd0, 64'd0, 1'b0, 2'd2, 1'b0), 1'b0, z);
    add_row(make_item(OP_ADD, 3'd1, 64'd5, 1'b0, 2'd0, 1'b0), 1'b0, z);
    add_row(make_item(OP_CHECK, 3'd0, 64'd0, 1'b0, 2'd0, 1'b0), 1'b0, z);
    add_row(make_item(OP_COMMIT, 3'd0, 64'd0, 1'b0, ACT_INVALID, 1'b0), 1'b1, z);

    in_valid_i <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      out_item_t p;
      send_item(dir_rows[i].it, 1'b1);
      p = expected_q[$];
      if (dir_rows[i].typed && p !== dir_rows[i].want) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d: expected %p predicted %p",
                                       i, dir_rows[i].want, p);
      end
    end

    // random part; sender keeps offering during the receiver hold-off
    sent = 0;
    while (sent < 1400) begin
      if (sent == 700) begin
        in_valid_i <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk_i);
      end
      // send a random item, most of the time after a random gap
      send_item(random_item(), $urandom_range(0, 4) != 0);
      sent++;
    end
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("resource_hazard_scoreboard_tb passed");
    else
      $display("resource_hazard_scoreboard_tb failed");
    $finish;
  end

endmodule

[resource_hazard_scoreboard.f]
rtl/core/rhs_pkg.sv
rtl/core/rhs_datapath.sv
rtl/core/rhs_ctrl.sv
rtl/core/resource_hazard_scoreboard.sv
sim/resource_hazard_scoreboard_tb.sv
